// ===== hw/rtl/prbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prbs_pkg
// Shared types, register codes and the built-in feedback table of the PRBS
// level generator.
// ----------------------------------------------------------------------------
package prbs_pkg;

  localparam int unsigned MAX_LENGTH = 16;
  localparam int unsigned LFSR_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LEVEL_W    = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SWING       = 3'd6;

  // settings as seen by the datapath, already checked
  typedef struct packed {
    logic [4:0]         reg_count;
    logic [LFSR_W-1:0]  seed;
    logic [LFSR_W-1:0]  taps;
    logic [LFSR_W-1:0]  mask;
    logic [15:0]        period;
    logic [31:0]        start_delay;
    logic signed [15:0] mean;
    logic [14:0]        swing;
    logic               err;
  } prbs_cfg_t;

  // maximal-length feedback sets, bit i means tap i+1
  function automatic logic [LFSR_W-1:0] builtin_taps(input logic [4:0] n);
    logic [LFSR_W-1:0] t;
    case (n)
      5'd2:    t = 16'h0003;
      5'd3:    t = 16'h0006;
      5'd4:    t = 16'h000C;
      5'd5:    t = 16'h0014;
      5'd6:    t = 16'h0030;
      5'd7:    t = 16'h0060;
      5'd8:    t = 16'h00B8;
      5'd9:    t = 16'h0110;
      5'd10:   t = 16'h0240;
      5'd11:   t = 16'h0500;
      5'd12:   t = 16'h0E08;
      5'd13:   t = 16'h1C80;
      5'd14:   t = 16'h3802;
      5'd15:   t = 16'h6000;
      5'd16:   t = 16'hD008;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/prbs_lfsr_signal_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prbs_lfsr_signal_generator_core
// PRBS excitation level generator, one level per tick.
// ----------------------------------------------------------------------------
// Every accepted transaction is one tick and returns one level through the input
// register and the result register; a new tick is taken in every cycle while the
// output side is not stalled. The tick stage lies between the two registers: the
// shift register, the delay counter and the hold counter are all updated together
// from their previous values. Configuration writes
// land immediately and are meant to be made while no tick is in flight; a new
// seed takes effect at the next tick that carries restart.
module prbs_lfsr_signal_generator_core
  import prbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_restart,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [LEVEL_W-1:0]  out_level,
  output logic                       out_prbs_bit,
  output logic                       out_config_error,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  prbs_cfg_t cfg;

  logic                      in_vld_r;
  logic                      restart_r;
  logic                      advance;
  logic signed [LEVEL_W-1:0] level;
  logic                      prbs_bit;
  logic                      config_error;

  prbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // tick moves from the input register to the result register
  assign advance  = in_vld_r && (!out_valid || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      restart_r <= in_restart;
    end
  end

  prbs_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .restart      (restart_r),
    .cfg          (cfg),
    .level        (level),
    .prbs_bit     (prbs_bit),
    .config_error (config_error)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_level        <= level;
      out_prbs_bit     <= prbs_bit;
      out_config_error <= config_error;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/prbs_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prbs_cfg_regs
// Configuration register file with length, seed and tap checks.
// ----------------------------------------------------------------------------
module prbs_cfg_regs
  import prbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output prbs_cfg_t                  cfg
);

  logic [4:0]         reg_count_r;
  logic [15:0]        seed_r;
  logic [15:0]        tap_mask_r;
  logic [15:0]        period_r;
  logic [31:0]        start_delay_r;
  logic signed [15:0] mean_r;
  logic [14:0]        swing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_count_r   <= 5'd16;
      seed_r        <= 16'd1;
      tap_mask_r    <= '0;
      period_r      <= 16'd1;
      start_delay_r <= '0;
      mean_r        <= '0;
      swing_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT:       reg_count_r   <= cfg_wdata[4:0];
        REG_SEED:        seed_r        <= cfg_wdata[15:0];
        REG_TAP_MASK:    tap_mask_r    <= cfg_wdata[15:0];
        REG_BIT_PERIOD:  period_r      <= cfg_wdata[15:0];
        REG_START_DELAY: start_delay_r <= cfg_wdata[31:0];
        REG_MEAN:        mean_r        <= cfg_wdata[15:0];
        REG_SWING:       swing_r       <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  logic [LFSR_W-1:0] mask;
  logic [LFSR_W-1:0] taps;
  logic              len_bad;

  always_comb begin
    len_bad = (reg_count_r < 5'd2) || (reg_count_r > 5'(MAX_LENGTH));
    if (reg_count_r >= 5'(LFSR_W)) begin
      mask = '1;
    end else begin
      mask = (16'd1 << reg_count_r[3:0]) - 16'd1;
    end
    taps = (tap_mask_r == '0) ? builtin_taps(reg_count_r) : tap_mask_r;

    cfg.reg_count   = reg_count_r;
    cfg.seed        = seed_r;
    cfg.taps        = taps;
    cfg.mask        = mask;
    cfg.period      = (period_r == '0) ? 16'd1 : period_r;
    cfg.start_delay = start_delay_r;
    cfg.mean        = mean_r;
    cfg.swing       = swing_r;
    cfg.err         = len_bad || (taps == '0) || ((tap_mask_r & ~mask) != '0) ||
                      (seed_r == '0) || ((seed_r & ~mask) != '0);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/prbs_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prbs_step
// Sequence state (shift register, delay and hold counters) and the one-tick
// update that yields the excitation level.
// ----------------------------------------------------------------------------
module prbs_step
  import prbs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic                restart,
  input  wire prbs_cfg_t           cfg,
  output logic signed [LEVEL_W-1:0] level,
  output logic                     prbs_bit,
  output logic                     config_error
);

  logic [LFSR_W-1:0] lfsr_r,    lfsr_nxt;
  logic [31:0]       delay_r,   delay_nxt;
  logic [15:0]       hold_r,    hold_nxt;
  logic              running_r, running_nxt;

  logic [LFSR_W-1:0] lfsr0, s;
  logic [31:0]       delay0;
  logic [15:0]       hold0;
  logic              run0, run1, bit_cur;
  logic [16:0]       hold_inc;
  logic [3:0]        top_idx;
  logic [LEVEL_W-1:0] mean_x, swing_x;

  always_comb begin
    // restart applies before this tick
    lfsr0  = restart ? cfg.seed : lfsr_r;
    delay0 = restart ? '0 : delay_r;
    hold0  = restart ? '0 : hold_r;
    run0   = restart ? 1'b0 : running_r;

    run1     = run0 || (delay0 >= cfg.start_delay);
    s        = lfsr0 & cfg.mask;
    top_idx  = 4'(cfg.reg_count - 5'd1);
    bit_cur  = run1 && s[top_idx];
    hold_inc = {1'b0, hold0} + 17'd1;

    lfsr_nxt    = lfsr0;
    delay_nxt   = delay0;
    hold_nxt    = hold0;
    running_nxt = run0;
    if (!cfg.err) begin
      running_nxt = run1;
      if (!run1) begin
        delay_nxt = delay0 + 32'd1;
      end else if (hold_inc >= {1'b0, cfg.period}) begin
        hold_nxt = '0;
        lfsr_nxt = {s[LFSR_W-2:0], ^(s & cfg.taps)} & cfg.mask;
      end else begin
        hold_nxt = hold_inc[15:0];
      end
    end

    mean_x  = {cfg.mean[15], cfg.mean};
    swing_x = {2'b00, cfg.swing};
    if (cfg.err || !run1) begin
      level = mean_x;
    end else if (bit_cur) begin
      level = mean_x + swing_x;
    end else begin
      level = mean_x - swing_x;
    end
    prbs_bit     = !cfg.err && bit_cur;
    config_error = cfg.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r    <= 16'd1;
      delay_r   <= '0;
      hold_r    <= '0;
      running_r <= 1'b0;
    end else if (step) begin
      lfsr_r    <= lfsr_nxt;
      delay_r   <= delay_nxt;
      hold_r    <= hold_nxt;
      running_r <= running_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/prbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prbs_checker
// Port-level checks of the PRBS level generator, bound to the top level.
// ----------------------------------------------------------------------------
module prbs_checker
  import prbs_pkg::*;
(
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic signed [LEVEL_W-1:0]   out_level,
  input wire logic                        out_prbs_bit,
  input wire logic                        out_config_error
);

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

  // an error result never carries a sequence bit
  a_err_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_config_error) |-> !out_prbs_bit)
    else $error("sequence bit set on error result");

  // an accepted tick reaches the output if the output is free
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("tick result missing");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_level) && $stable(out_prbs_bit) &&
       $stable(out_config_error)))
    else $error("stalled result changed");

endmodule

bind prbs_lfsr_signal_generator_core prbs_checker u_prbs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_level        (out_level),
  .out_prbs_bit     (out_prbs_bit),
  .out_config_error (out_config_error)
);
`default_nettype wire
